/* hdl/palette_hue_replace_assert.svh */
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef PALETTE_HUE_REPLACE_ASSERT_SVH
`define PALETTE_HUE_REPLACE_ASSERT_SVH

`define PHR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define PHR_ASSERT_NEVER(lbl, cond, msg) \
  `PHR_ASSERT(lbl, !(cond), msg)

`endif

/* hdl/phr_pkg.sv */
package phr_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HUE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_START  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_END    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HUE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_START = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_END   = 3'd5;

  localparam logic [7:0] RST_FIRST_HUE    = 8'd30;
  localparam logic [7:0] RST_FIRST_START  = 8'd192;
  localparam logic [7:0] RST_FIRST_END    = 8'd223;
  localparam logic [7:0] RST_SECOND_HUE   = 8'd6;
  localparam logic [7:0] RST_SECOND_START = 8'd160;
  localparam logic [7:0] RST_SECOND_END   = 8'd191;

  // hue circle of 255 codes, 85 codes per 120 degrees
  localparam logic [7:0] HUE_120 = 8'd85;
  localparam logic [7:0] HUE_240 = 8'd170;
  localparam logic [7:0] HUE_360 = 8'd255;
  localparam logic [7:0] HUE_SPLIT_RG = 8'd42;
  localparam logic [7:0] HUE_SPLIT_GB = 8'd127;
  localparam logic [7:0] HUE_SPLIT_BR = 8'd212;

  localparam int unsigned NUM_W  = 6;
  localparam int unsigned DEN_W  = 7;
  localparam int unsigned PROD_W = 14;
  localparam int unsigned REM_W  = 11;
  localparam int unsigned QH_W   = 4;

  typedef struct packed {
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } phr_pix_t;

  // first letter: channel at max, second letter: channel that interpolates
  typedef enum logic [2:0] {
    SECT_RG,
    SECT_GR,
    SECT_GB,
    SECT_BG,
    SECT_BR,
    SECT_RB
  } phr_sect_e;

  typedef struct packed {
    phr_sect_e        sect;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } phr_factor_t;

  function automatic phr_factor_t phr_factor(input logic [7:0] hue);
    phr_factor_t f;
    logic [7:0]  num8;
    logic [7:0]  den8;
    if (hue <= HUE_SPLIT_RG) begin
      f.sect = SECT_RG;
      num8   = hue;
      den8   = HUE_120 - hue;
    end else if (hue <= HUE_120) begin
      f.sect = SECT_GR;
      num8   = HUE_120 - hue;
      den8   = hue;
    end else if (hue <= HUE_SPLIT_GB) begin
      f.sect = SECT_GB;
      num8   = hue - HUE_120;
      den8   = HUE_240 - hue;
    end else if (hue <= HUE_240) begin
      f.sect = SECT_BG;
      num8   = HUE_240 - hue;
      den8   = hue - HUE_120;
    end else if (hue <= HUE_SPLIT_BR) begin
      f.sect = SECT_BR;
      num8   = hue - HUE_240;
      den8   = HUE_360 - hue;
    end else begin
      f.sect = SECT_RB;
      num8   = HUE_360 - hue;
      den8   = hue - HUE_240;
    end
    f.num = num8[NUM_W-1:0];
    f.den = den8[DEN_W-1:0];
    return f;
  endfunction

endpackage

/* hdl/phr_entry_if.sv */
interface phr_entry_if;
  logic       valid;
  logic       ready;
  logic [7:0] entry_index;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, entry_index, red_in, green_in, blue_in, input ready);
  modport sink (input valid, entry_index, red_in, green_in, blue_in, output ready);
endinterface

/* hdl/phr_result_if.sv */
interface phr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

/* hdl/phr_recolour.sv */
module phr_recolour (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  phr_pkg::phr_pix_t in_pix_i,
  input  logic [7:0]        hue_i,
  input  logic [7:0]        start_i,
  input  logic [7:0]        last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output phr_pkg::phr_pix_t out_pix_o
);
  import phr_pkg::*;

  // stage a: range check, max/min, sector decode, d*num
  logic              a_v_q;
  phr_pix_t          a_pix_q;
  logic              a_hit_q;
  logic [7:0]        a_mx_q, a_mn_q;
  phr_sect_e         a_sect_q;
  logic [DEN_W-1:0]  a_den_q;
  logic [PROD_W-1:0] a_rem_q;

  // stage b: upper four quotient bits
  logic              b_v_q;
  phr_pix_t          b_pix_q;
  logic              b_hit_q;
  logic [7:0]        b_mx_q, b_mn_q;
  phr_sect_e         b_sect_q;
  logic [DEN_W-1:0]  b_den_q;
  logic [QH_W-1:0]   b_qhi_q;
  logic [REM_W-1:0]  b_rem_q;

  // stage c: lower quotient bits and channel placement
  logic              c_v_q;
  phr_pix_t          c_pix_q;

  logic a_rdy, b_rdy, c_rdy;

  logic              a_hit_d;
  logic [7:0]        a_mx_d, a_mn_d;
  phr_factor_t       a_fac;
  logic [PROD_W-1:0] a_rem_d;

  logic [QH_W-1:0]   b_qhi_d;
  logic [REM_W-1:0]  b_rem_d;

  phr_pix_t          c_pix_d;

  assign c_rdy      = !c_v_q || out_ready_i;
  assign b_rdy      = !b_v_q || c_rdy;
  assign a_rdy      = !a_v_q || b_rdy;
  assign in_ready_o = a_rdy;

  always_comb begin
    logic [7:0] r, g, b, d;
    r = in_pix_i.red;
    g = in_pix_i.green;
    b = in_pix_i.blue;
    a_hit_d = (in_pix_i.entry_index >= start_i) && (in_pix_i.entry_index <= last_i);
    a_mx_d = r;
    if (g > a_mx_d) a_mx_d = g;
    if (b > a_mx_d) a_mx_d = b;
    a_mn_d = r;
    if (g < a_mn_d) a_mn_d = g;
    if (b < a_mn_d) a_mn_d = b;
    d       = a_mx_d - a_mn_d;
    a_fac   = phr_factor(hue_i);
    a_rem_d = PROD_W'(d) * PROD_W'(a_fac.num);
  end

  // restoring division, quotient bits 7..4
  always_comb begin
    logic [PROD_W-1:0] rem;
    logic [PROD_W:0]   trial;
    rem     = a_rem_q;
    b_qhi_d = '0;
    for (int i = 0; i < QH_W; i++) begin
      trial = (PROD_W+1)'(a_den_q) << (7 - i);
      if ({1'b0, rem} >= trial) begin
        rem             = rem - trial[PROD_W-1:0];
        b_qhi_d[3 - i]  = 1'b1;
      end
    end
    b_rem_d = rem[REM_W-1:0];
  end

  // quotient bits 3..0, then comp = min + quotient
  always_comb begin
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] trial;
    logic [3:0]       qlo;
    logic [7:0]       comp;
    rem = b_rem_q;
    qlo = '0;
    for (int i = 0; i < 4; i++) begin
      trial = REM_W'(b_den_q) << (3 - i);
      if (rem >= trial) begin
        rem        = rem - trial;
        qlo[3 - i] = 1'b1;
      end
    end
    comp    = b_mn_q + {b_qhi_q, qlo};
    c_pix_d = b_pix_q;
    if (b_hit_q) begin
      case (b_sect_q)
        SECT_RG: begin
          c_pix_d.red = b_mx_q; c_pix_d.green = comp;   c_pix_d.blue = b_mn_q;
        end
        SECT_GR: begin
          c_pix_d.red = comp;   c_pix_d.green = b_mx_q; c_pix_d.blue = b_mn_q;
        end
        SECT_GB: begin
          c_pix_d.red = b_mn_q; c_pix_d.green = b_mx_q; c_pix_d.blue = comp;
        end
        SECT_BG: begin
          c_pix_d.red = b_mn_q; c_pix_d.green = comp;   c_pix_d.blue = b_mx_q;
        end
        SECT_BR: begin
          c_pix_d.red = comp;   c_pix_d.green = b_mn_q; c_pix_d.blue = b_mx_q;
        end
        SECT_RB: begin
          c_pix_d.red = b_mx_q; c_pix_d.green = b_mn_q; c_pix_d.blue = comp;
        end
        default: begin
          c_pix_d = b_pix_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= in_valid_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      a_pix_q  <= in_pix_i;
      a_hit_q  <= a_hit_d;
      a_mx_q   <= a_mx_d;
      a_mn_q   <= a_mn_d;
      a_sect_q <= a_fac.sect;
      a_den_q  <= a_fac.den;
      a_rem_q  <= a_rem_d;
    end
    if (b_rdy && a_v_q) begin
      b_pix_q  <= a_pix_q;
      b_hit_q  <= a_hit_q;
      b_mx_q   <= a_mx_q;
      b_mn_q   <= a_mn_q;
      b_sect_q <= a_sect_q;
      b_den_q  <= a_den_q;
      b_qhi_q  <= b_qhi_d;
      b_rem_q  <= b_rem_d;
    end
    if (c_rdy && b_v_q) begin
      c_pix_q <= c_pix_d;
    end
  end

  assign out_valid_o = c_v_q;
  assign out_pix_o   = c_pix_q;

endmodule

/* hdl/palette_hue_replace.sv */
// palette_hue_replace: moves palette entries to a configured hue while keeping
// each entry's largest and smallest channel.
// entry_i takes one entry per transaction (index, red, green, blue) and
// result_o returns the recolored red, green, blue in the same order.
// entries whose index lies in the first range are recolored with first_hue,
// then entries in the second range with second_hue; others pass unchanged.
// configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 first_hue, 1 first_start, 2 first_end, 3 second_hue, 4 second_start,
// 5 second_end); other indexes are ignored. write only while the pipe is empty.
// three register stages per hue region (max/min and multiply, two four-bit
// division steps) lie between an accepted entry and its result.
// throughput: one entry per cycle while the pipe is not held by a stalled result.
// a stalled result holds; stages behind it keep filling until every stage
// holds an entry, so up to six entries are held without loss.
// reset: pipeline empty, registers at 30, 192, 223, 6, 160, 191.
`include "palette_hue_replace_assert.svh"

module palette_hue_replace (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  phr_entry_if.sink                       entry_i,
  phr_result_if.source                    result_o,
  input  logic                            cfg_we_i,
  input  logic [phr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [7:0]                      cfg_data_i
);
  import phr_pkg::*;

  logic [7:0] first_hue_q, first_start_q, first_end_q;
  logic [7:0] second_hue_q, second_start_q, second_end_q;

  phr_pix_t in_pix, mid_pix, out_pix;
  logic     mid_valid, mid_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_hue_q    <= RST_FIRST_HUE;
      first_start_q  <= RST_FIRST_START;
      first_end_q    <= RST_FIRST_END;
      second_hue_q   <= RST_SECOND_HUE;
      second_start_q <= RST_SECOND_START;
      second_end_q   <= RST_SECOND_END;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIRST_HUE:    first_hue_q    <= cfg_data_i;
        CFG_FIRST_START:  first_start_q  <= cfg_data_i;
        CFG_FIRST_END:    first_end_q    <= cfg_data_i;
        CFG_SECOND_HUE:   second_hue_q   <= cfg_data_i;
        CFG_SECOND_START: second_start_q <= cfg_data_i;
        CFG_SECOND_END:   second_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_pix.entry_index = entry_i.entry_index;
  assign in_pix.red         = entry_i.red_in;
  assign in_pix.green       = entry_i.green_in;
  assign in_pix.blue        = entry_i.blue_in;

  phr_recolour u_first (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (entry_i.valid),
    .in_ready_o  (entry_i.ready),
    .in_pix_i    (in_pix),
    .hue_i       (first_hue_q),
    .start_i     (first_start_q),
    .last_i      (first_end_q),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_pix_o   (mid_pix)
  );

  // second region sees the first region's result
  phr_recolour u_second (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_pix_i    (mid_pix),
    .hue_i       (second_hue_q),
    .start_i     (second_start_q),
    .last_i      (second_end_q),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_pix_o   (out_pix)
  );

  assign result_o.red_out   = out_pix.red;
  assign result_o.green_out = out_pix.green;
  assign result_o.blue_out  = out_pix.blue;

  `PHR_ASSERT(a_ready_follows_sink, result_o.ready |-> entry_i.ready, "pipe stalls with sink ready")
  `PHR_ASSERT_NEVER(a_mid_empty_stall, !mid_valid && !entry_i.ready, "first region stalls while empty")
  `PHR_ASSERT(a_mid_hold, mid_valid && !mid_ready |=> mid_valid, "mid transaction dropped")
  `PHR_ASSERT(a_cfg_hold, !cfg_we_i |=> $stable(first_hue_q) && $stable(second_hue_q), "hue changed without write")

endmodule
